/* hdl/tdp_pkg.sv */
// Shared types and constants for the trial-division prime test.
package tdp_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_DONE
    } tdp_state_t;

    // status of the remainder unit back to the sequencer
    typedef struct packed {
        logic done;
        logic rem_zero;
    } tdp_div_stat_t;

endpackage

/* hdl/tdp_divider.sv */
// Restoring remainder unit, one quotient bit per cycle.
module tdp_divider #(
    parameter int DIVIDEND_W = tdp_pkg::DATA_WIDTH_DEF,
    parameter int DIVISOR_W  = tdp_pkg::DATA_WIDTH_DEF / 2 + 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [DIVIDEND_W-1:0]   dividend,
    input  logic [DIVISOR_W-1:0]    divisor,
    output tdp_pkg::tdp_div_stat_t  stat
);

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    always_comb begin
        trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff  = trial - {1'b0, divisor};
        fits  = (trial >= {1'b0, divisor});
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            // trial below divisor fits in the narrower remainder
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign stat.done     = done_reg;
    assign stat.rem_zero = (rem_reg == '0);

endmodule

/* hdl/trial_division_prime_test.sv */
// Top level of the trial-division prime test: sequencer, square tracking and result register.
//
// Channel   Dir  tdata fields (low bit up)       Notes
// s_        in   number[DATA_WIDTH-1:0]          padded to whole bytes
// m_        out  prime_flag[0]                   padded to 8 bits
//
// Steps: accept, then per trial divisor a square compare and a restoring division;
// worst case 46339 trials at DATA_WIDTH 32. Values below 2 and negatives go from
// accept straight to done. The remainder unit sets the pace.
// Reset: aresetn synchronous, active low; clears sequencer and output valid.
// s_tready is high only while idle; a finished request waits in the output
// register, and a new one is taken meanwhile.
module trial_division_prime_test #(
    parameter int DATA_WIDTH = tdp_pkg::DATA_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((DATA_WIDTH+7)/8)*8-1:0]   s_tdata,   // [DATA_WIDTH-1:0] number
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata    // [0] prime_flag
);

    localparam int DIV_W = DATA_WIDTH / 2 + 1;

    tdp_pkg::tdp_state_t   state_reg, state_next;
    logic [DATA_WIDTH-1:0] number_reg, number_next;
    logic [DIV_W-1:0]      divisor_reg, divisor_next;
    logic [DATA_WIDTH-1:0] square_reg, square_next;
    logic                  result_reg, result_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  prime_reg, prime_next;

    logic                  accept;
    logic                  trivial;
    logic                  square_over;
    logic                  div_start;
    logic                  load_out;
    tdp_pkg::tdp_div_stat_t div_stat;

    assign accept      = s_tvalid && s_tready;
    // negative, zero and one are never prime
    assign trivial     = s_tdata[DATA_WIDTH-1] || (s_tdata[DATA_WIDTH-1:0] < DATA_WIDTH'(2));
    assign square_over = (square_reg > number_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tdp_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = trivial ? tdp_pkg::ST_DONE : tdp_pkg::ST_CHECK;
                end
            end
            tdp_pkg::ST_CHECK: begin
                state_next = square_over ? tdp_pkg::ST_DONE : tdp_pkg::ST_DIVIDE;
            end
            tdp_pkg::ST_DIVIDE: begin
                if (div_stat.done) begin
                    state_next = div_stat.rem_zero ? tdp_pkg::ST_DONE : tdp_pkg::ST_CHECK;
                end
            end
            tdp_pkg::ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = tdp_pkg::ST_IDLE;
                end
            end
            default: state_next = tdp_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_tready     = 1'b0;
        div_start    = 1'b0;
        load_out     = 1'b0;
        number_next  = number_reg;
        divisor_next = divisor_reg;
        square_next  = square_reg;
        result_next  = result_reg;
        case (state_reg)
            tdp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    number_next  = s_tdata[DATA_WIDTH-1:0];
                    divisor_next = DIV_W'(2);
                    square_next  = DATA_WIDTH'(4);
                    result_next  = 1'b0;
                end
            end
            tdp_pkg::ST_CHECK: begin
                if (square_over) begin
                    result_next = 1'b1;
                end else begin
                    div_start = 1'b1;
                end
            end
            tdp_pkg::ST_DIVIDE: begin
                if (div_stat.done && !div_stat.rem_zero) begin
                    // (d+1)^2 = d^2 + 2d + 1
                    square_next  = square_reg + DATA_WIDTH'({divisor_reg, 1'b1});
                    divisor_next = divisor_reg + 1'b1;
                end
            end
            tdp_pkg::ST_DONE: begin
                load_out = !m_valid_reg || m_tready;
            end
            default: ;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        prime_next   = prime_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
            prime_next   = result_reg;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tdp_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        number_reg  <= number_next;
        divisor_reg <= divisor_next;
        square_reg  <= square_next;
        result_reg  <= result_next;
        prime_reg   <= prime_next;
    end

    tdp_divider #(
        .DIVIDEND_W (DATA_WIDTH),
        .DIVISOR_W  (DIV_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (number_reg),
        .divisor  (divisor_reg),
        .stat     (div_stat)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, prime_reg};

    a_done_in_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == tdp_pkg::ST_DIVIDE))
        else $error("remainder unit finished outside divide state");

    a_prime_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && result_reg) |->
            (!number_reg[DATA_WIDTH-1] && (number_reg >= DATA_WIDTH'(2))))
        else $error("prime answer for a value below two");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != tdp_pkg::ST_IDLE))
        else $error("sequencer stayed idle after a request");

    a_start_check: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> ((state_reg == tdp_pkg::ST_CHECK) && !square_over))
        else $error("division started without a passing square test");

endmodule
